FILE: rtl/bffl_pkg.sv
`default_nettype none

package bffl_pkg;

  // Field widths fixed by the interface.
  localparam int REQ_W = 18;
  localparam int ADDR_W = 18;
  localparam int CFG_W = 15;

  // Operation codes carried by in_cmd.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  // Result status codes.
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  // Register indexes on the configuration port (paddr[2]).
  localparam logic REG_CHUNK = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] CHUNK_RESET = 15'd1024;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 15'd16384;

  // One datapath action per cycle, chosen by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_TAKE,
    OP_SPLIT,
    OP_GROW,
    OP_FREE_RD,
    OP_FREE_TAKE,
    OP_INS_EMPTY,
    OP_INS_EVAL,
    OP_INS_WRITE,
    OP_INS_LINK,
    OP_EMIT,
    OP_EMIT_FAIL
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic free_pre;
    logic empty;
    logic walk_last;
    logic best_v;
    logic best_exact;
    logic grow_ok;
    logic free_ok;
    logic ins_bad;
    logic need_link;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bffl_ram.sv
`default_nettype none

module bffl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bffl_ctrl.sv
`default_nettype none

module bffl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bffl_pkg::dp_stat_t stat,
  output bffl_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_AWALK,
    S_TAKE,
    S_SPLIT,
    S_GROW,
    S_FCHK,
    S_INS,
    S_IWALK,
    S_IEVAL,
    S_IWRITE,
    S_ILINK,
    S_INS_END,
    S_FAIL,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   retry_r, retry_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    retry_nxt = retry_r;
    cmd.op = bffl_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = bffl_pkg::OP_LOAD;
          retry_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_free) begin
          if (stat.free_pre) begin
            cmd.op = bffl_pkg::OP_FREE_RD;
            state_nxt = S_FCHK;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (stat.empty) begin
          state_nxt = S_GROW;
        end else begin
          cmd.op = bffl_pkg::OP_WALK_START;
          state_nxt = S_AWALK;
        end
      end
      S_AWALK: begin
        cmd.op = bffl_pkg::OP_WALK_STEP;
        if (stat.walk_last) begin
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        if (stat.best_v) begin
          cmd.op = bffl_pkg::OP_TAKE;
          state_nxt = stat.best_exact ? S_FINISH : S_SPLIT;
        end else if (retry_r) begin
          state_nxt = S_FAIL;
        end else begin
          state_nxt = S_GROW;
        end
      end
      S_SPLIT: begin
        cmd.op = bffl_pkg::OP_SPLIT;
        state_nxt = S_FINISH;
      end
      S_GROW: begin
        if (stat.grow_ok) begin
          cmd.op = bffl_pkg::OP_GROW;
          retry_nxt = 1'b1;
          state_nxt = S_INS;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_FCHK: begin
        if (stat.free_ok) begin
          cmd.op = bffl_pkg::OP_FREE_TAKE;
          state_nxt = S_INS;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_INS: begin
        if (stat.empty) begin
          cmd.op = bffl_pkg::OP_INS_EMPTY;
          state_nxt = S_INS_END;
        end else begin
          cmd.op = bffl_pkg::OP_WALK_START;
          state_nxt = S_IWALK;
        end
      end
      S_IWALK: begin
        cmd.op = bffl_pkg::OP_WALK_STEP;
        if (stat.walk_last) begin
          state_nxt = S_IEVAL;
        end
      end
      S_IEVAL: begin
        cmd.op = bffl_pkg::OP_INS_EVAL;
        state_nxt = S_IWRITE;
      end
      S_IWRITE: begin
        if (stat.ins_bad) begin
          state_nxt = S_INS_END;
        end else begin
          cmd.op = bffl_pkg::OP_INS_WRITE;
          state_nxt = stat.need_link ? S_ILINK : S_INS_END;
        end
      end
      S_ILINK: begin
        cmd.op = bffl_pkg::OP_INS_LINK;
        state_nxt = S_INS_END;
      end
      S_INS_END: begin
        if (stat.is_free) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op = bffl_pkg::OP_WALK_START;
          state_nxt = S_AWALK;
        end
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.op = bffl_pkg::OP_EMIT_FAIL;
          state_nxt = S_IDLE;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.op = bffl_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      retry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      retry_r <= retry_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bffl_dp.sv
`default_nettype none

module bffl_dp #(
  parameter int ARENA_UNITS = 16384,
  parameter int UNIT_BYTES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_cmd,
  input  wire logic [bffl_pkg::REQ_W-1:0]    in_req_bytes,
  input  wire logic [bffl_pkg::ADDR_W-1:0]   in_free_addr,
  input  wire logic [bffl_pkg::CFG_W-1:0]    chunk_units,
  input  wire logic [bffl_pkg::CFG_W-1:0]    heap_limit_units,
  input  wire logic                          out_stall,
  input  wire bffl_pkg::dp_cmd_t             cmd,
  output bffl_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output logic                               out_status,
  output logic      [bffl_pkg::ADDR_W-1:0]   out_payload_addr
);

  localparam int AW = $clog2(ARENA_UNITS);
  localparam int SW = $clog2(ARENA_UNITS + 1);
  localparam int UBL = $clog2(UNIT_BYTES);
  localparam int CW = ((SW > 19) ? SW : 19) + 1;
  localparam int PW = 40;

  // Memory ports.
  logic          sz_we, nx_we;
  logic [AW-1:0] sz_waddr, nx_waddr, rd_addr;
  logic [SW-1:0] sz_wdata, sz_rd;
  logic [AW-1:0] nx_wdata, nx_rd;

  // List state.
  logic [AW-1:0] head_r;
  logic          empty_r;
  logic [SW-1:0] heap_top_r;

  // Operation registers.
  logic          is_free_r, free_pre_r;
  logic [CW-1:0] n_r, grow_r, limit_r;
  logic [AW-1:0] ins_bp_r;
  logic [SW-1:0] ins_sz_r;

  // Walk trackers.
  logic [AW-1:0] cur_r, prv_r, tail_r;
  logic          prv_v_r;
  logic [AW-1:0] best_r, best_prev_r, best_next_r;
  logic          best_v_r, best_prev_v_r;
  logic [SW-1:0] best_size_r;
  logic [AW-1:0] pred_r, succ_r, succ_next_r;
  logic          pred_v_r, succ_v_r;
  logic [SW-1:0] pred_size_r, succ_size_r;

  // Insert decisions.
  logic          ins_bad_r, mdown_r, need_link_r;
  logic [SW-1:0] new_sz_r;
  logic [AW-1:0] nn_r, link_addr_r;

  // Result.
  logic          res_hit_r;
  logic [AW-1:0] res_addr_r;
  logic [SW-1:0] rest_r;
  logic          out_valid_r, out_status_r;
  logic [bffl_pkg::ADDR_W-1:0] out_payload_r;

  bffl_ram #(.WIDTH(SW), .DEPTH(ARENA_UNITS)) u_size_ram (
    .clk     (clk),
    .we      (sz_we),
    .waddr   (sz_waddr),
    .wdata   (sz_wdata),
    .raddr   (rd_addr),
    .rdata_r (sz_rd)
  );

  bffl_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS)) u_next_ram (
    .clk     (clk),
    .we      (nx_we),
    .waddr   (nx_waddr),
    .wdata   (nx_wdata),
    .raddr   (rd_addr),
    .rdata_r (nx_rd)
  );

  // Input decoding for the load cycle.
  logic [CW-1:0] n_w, chunk_w, limit_cfg_w, bp_w;
  logic          fa_ok;

  assign n_w = CW'((CW'(in_req_bytes) + CW'(UNIT_BYTES - 1)) >> UBL) + CW'(1);
  assign chunk_w = CW'(chunk_units);
  assign limit_cfg_w = CW'(heap_limit_units);
  assign bp_w = CW'(in_free_addr >> UBL) - CW'(1);
  assign fa_ok = (in_free_addr[UBL-1:0] == '0)
              && (CW'(in_free_addr) >= CW'(UNIT_BYTES));

  // Walk and allocation terms.
  logic          fit, better, exact;
  logic [SW-1:0] rest;
  logic [AW-1:0] split_addr;

  assign fit = CW'(sz_rd) >= n_r;
  assign better = !best_v_r || (sz_rd < best_size_r);
  assign exact = CW'(best_size_r) == n_r;
  assign rest = best_size_r - n_r[SW-1:0];
  assign split_addr = best_r + rest_r[AW-1:0];

  // Insert evaluation terms.
  logic [CW-1:0] pred_end, bp_end;

  assign pred_end = CW'(pred_r) + CW'(pred_size_r);
  assign bp_end = CW'(ins_bp_r) + CW'(ins_sz_r);

  logic [PW-1:0] pay_w;
  assign pay_w = (PW'(res_addr_r) + PW'(1)) << UBL;

  always_comb begin
    stat.is_free = is_free_r;
    stat.free_pre = free_pre_r;
    stat.empty = empty_r;
    stat.walk_last = (nx_rd == head_r);
    stat.best_v = best_v_r;
    stat.best_exact = exact;
    stat.grow_ok = (CW'(heap_top_r) + grow_r) <= limit_r;
    stat.free_ok = (sz_rd != '0)
                && (CW'(sz_rd) <= (CW'(heap_top_r) - CW'(ins_bp_r)));
    stat.ins_bad = ins_bad_r;
    stat.need_link = need_link_r;
    stat.out_free = !out_valid_r || !out_stall;
  end

  // Memory port selection.
  always_comb begin
    rd_addr = head_r;
    sz_we = 1'b0;
    sz_waddr = best_r;
    sz_wdata = rest;
    nx_we = 1'b0;
    nx_waddr = link_addr_r;
    nx_wdata = ins_bp_r;
    unique case (cmd.op)
      bffl_pkg::OP_WALK_STEP: rd_addr = nx_rd;
      bffl_pkg::OP_FREE_RD:   rd_addr = ins_bp_r;
      bffl_pkg::OP_TAKE: begin
        if (exact) begin
          if (best_next_r != best_r) begin
            nx_we = 1'b1;
            nx_waddr = best_prev_v_r ? best_prev_r : tail_r;
            nx_wdata = best_next_r;
          end
        end else begin
          sz_we = 1'b1;
        end
      end
      bffl_pkg::OP_SPLIT: begin
        sz_we = 1'b1;
        sz_waddr = split_addr;
        sz_wdata = n_r[SW-1:0];
      end
      bffl_pkg::OP_INS_EMPTY: begin
        sz_we = 1'b1;
        sz_waddr = ins_bp_r;
        sz_wdata = ins_sz_r;
        nx_we = 1'b1;
        nx_waddr = ins_bp_r;
        nx_wdata = ins_bp_r;
      end
      bffl_pkg::OP_INS_WRITE: begin
        sz_we = 1'b1;
        nx_we = 1'b1;
        nx_wdata = nn_r;
        if (mdown_r) begin
          sz_waddr = pred_r;
          sz_wdata = pred_size_r + new_sz_r;
          nx_waddr = pred_r;
        end else begin
          sz_waddr = ins_bp_r;
          sz_wdata = new_sz_r;
          nx_waddr = ins_bp_r;
        end
      end
      bffl_pkg::OP_INS_LINK: nx_we = 1'b1;
      default: ;
    endcase
  end

  // Operation and walk registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bffl_pkg::OP_LOAD: begin
        is_free_r <= (in_cmd == bffl_pkg::CMD_FREE);
        n_r <= n_w;
        grow_r <= (n_w > chunk_w) ? n_w : chunk_w;
        limit_r <= (limit_cfg_w < CW'(ARENA_UNITS)) ? limit_cfg_w : CW'(ARENA_UNITS);
        ins_bp_r <= bp_w[AW-1:0];
        free_pre_r <= fa_ok && (bp_w < CW'(heap_top_r));
        res_hit_r <= 1'b0;
      end
      bffl_pkg::OP_WALK_START: begin
        cur_r <= head_r;
        prv_v_r <= 1'b0;
        best_v_r <= 1'b0;
        pred_v_r <= 1'b0;
        succ_v_r <= 1'b0;
      end
      bffl_pkg::OP_WALK_STEP: begin
        if (fit && better) begin
          best_r <= cur_r;
          best_v_r <= 1'b1;
          best_size_r <= sz_rd;
          best_next_r <= nx_rd;
          best_prev_r <= prv_r;
          best_prev_v_r <= prv_v_r;
        end
        if (cur_r < ins_bp_r) begin
          pred_r <= cur_r;
          pred_v_r <= 1'b1;
          pred_size_r <= sz_rd;
        end else if (!succ_v_r) begin
          succ_r <= cur_r;
          succ_v_r <= 1'b1;
          succ_size_r <= sz_rd;
          succ_next_r <= nx_rd;
        end
        tail_r <= cur_r;
        prv_r <= cur_r;
        prv_v_r <= 1'b1;
        cur_r <= nx_rd;
      end
      bffl_pkg::OP_TAKE: begin
        res_hit_r <= 1'b1;
        res_addr_r <= best_r;
        rest_r <= rest;
      end
      bffl_pkg::OP_SPLIT: res_addr_r <= split_addr;
      bffl_pkg::OP_GROW: begin
        ins_bp_r <= heap_top_r[AW-1:0];
        ins_sz_r <= grow_r[SW-1:0];
      end
      bffl_pkg::OP_FREE_TAKE: ins_sz_r <= sz_rd;
      bffl_pkg::OP_INS_EVAL: begin
        ins_bad_r <= (pred_v_r && (pred_end > CW'(ins_bp_r)))
                  || (succ_v_r && (bp_end > CW'(succ_r)));
        mdown_r <= pred_v_r && (pred_end == CW'(ins_bp_r));
        // Merge with the hole right above, if the block touches it.
        if (succ_v_r && (bp_end == CW'(succ_r))) begin
          new_sz_r <= ins_sz_r + succ_size_r;
          nn_r <= (succ_next_r == succ_r) ? ins_bp_r : succ_next_r;
          need_link_r <= !(pred_v_r && (pred_end == CW'(ins_bp_r)))
                      && (pred_v_r || (tail_r != succ_r));
        end else begin
          new_sz_r <= ins_sz_r;
          nn_r <= succ_v_r ? succ_r : head_r;
          need_link_r <= !(pred_v_r && (pred_end == CW'(ins_bp_r)));
        end
        link_addr_r <= pred_v_r ? pred_r : tail_r;
      end
      bffl_pkg::OP_EMIT: begin
        out_status_r <= bffl_pkg::ST_DONE;
        out_payload_r <= res_hit_r ? pay_w[bffl_pkg::ADDR_W-1:0] : '0;
      end
      bffl_pkg::OP_EMIT_FAIL: begin
        out_status_r <= bffl_pkg::ST_NO_SPACE;
        out_payload_r <= '0;
      end
      default: ;
    endcase
  end

  // List state and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      empty_r <= 1'b1;
      heap_top_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((cmd.op == bffl_pkg::OP_EMIT) || (cmd.op == bffl_pkg::OP_EMIT_FAIL)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        bffl_pkg::OP_TAKE: begin
          if (exact) begin
            if (best_next_r == best_r) begin
              empty_r <= 1'b1;
            end else if (best_r == head_r) begin
              head_r <= best_next_r;
            end
          end
        end
        bffl_pkg::OP_GROW: heap_top_r <= heap_top_r + grow_r[SW-1:0];
        bffl_pkg::OP_INS_EMPTY: begin
          head_r <= ins_bp_r;
          empty_r <= 1'b0;
        end
        bffl_pkg::OP_INS_WRITE: begin
          if (!mdown_r && !pred_v_r) begin
            head_r <= ins_bp_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_payload_addr = out_payload_r;

endmodule

`default_nettype wire

FILE: rtl/best_fit_free_list_allocator.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_cmd, in_req_bytes, in_free_addr
// out_      output     out_valid/out_stall  out_status, out_payload_addr
// config    APB write  psel/penable/pwrite  paddr, pwdata, prdata (pready high)
//
// One operation is taken at a time. An allocate walks the hole list for the
// best fit, and walks it again after inserting a new chunk when the heap must
// grow; a free walks it to insert the freed block. The walk steps one hole per
// cycle through the registered header memory read port.
// Reset is synchronous and active low; the header memory is not cleared.
// A result waiting under out_stall does not block the next input transfer.
`default_nettype none

module best_fit_free_list_allocator #(
  parameter int ARENA_UNITS = 16384,
  parameter int UNIT_BYTES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_cmd,
  input  wire logic [bffl_pkg::REQ_W-1:0]  in_req_bytes,
  input  wire logic [bffl_pkg::ADDR_W-1:0] in_free_addr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic      [bffl_pkg::ADDR_W-1:0] out_payload_addr,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  // Configuration registers. Register index is paddr[2].
  logic [bffl_pkg::CFG_W-1:0] chunk_r, limit_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= bffl_pkg::CHUNK_RESET;
      limit_r <= bffl_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == bffl_pkg::REG_LIMIT) begin
        limit_r <= pwdata[bffl_pkg::CFG_W-1:0];
      end else begin
        chunk_r <= pwdata[bffl_pkg::CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == bffl_pkg::REG_LIMIT) ? 32'(limit_r) : 32'(chunk_r);

  // The controller sequences the walk; the datapath holds the list state,
  // the header memories and the result register.
  bffl_pkg::dp_cmd_t  cmd;
  bffl_pkg::dp_stat_t stat;

  bffl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bffl_dp #(
    .ARENA_UNITS (ARENA_UNITS),
    .UNIT_BYTES  (UNIT_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_req_bytes     (in_req_bytes),
    .in_free_addr     (in_free_addr),
    .chunk_units      (chunk_r),
    .heap_limit_units (limit_r),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_payload_addr (out_payload_addr)
  );

endmodule

`default_nettype wire
